// File: rtl/core/lrl_pkg.sv
// Shared types and constants for the LRU replacement list.
`timescale 1ns / 1ps
`default_nettype none
package lrl_pkg;

  localparam int unsigned FRAMES_DEF = 64;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned SIZE_W     = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_VICTIM = 2'd1,
    REQ_ERASE  = 2'd2
  } req_e;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic               accept;     // item taken this cycle: latch compare result
    logic               find;       // request looks the frame up (insert, erase)
    logic [FRAME_W-1:0] cmp_frame;  // frame to look up
    logic               exec;       // update cycle
    logic               ins;        // append ins_frame at the tail
    logic [FRAME_W-1:0] ins_frame;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/lrl_cell.sv
// One list position: frame, valid bit, match flag and shift/append logic.
`timescale 1ns / 1ps
`default_nettype none
module lrl_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lrl_pkg::cell_ctl_t          ctl_i,
  input  wire logic                        shift_i,
  output logic                             shift_o,
  input  wire logic                        next_valid_i,
  input  wire logic [lrl_pkg::FRAME_W-1:0] next_frame_i,
  input  wire logic                        prev_post_valid_i,
  output logic                             post_valid_o,
  output logic                             valid_o,
  output logic [lrl_pkg::FRAME_W-1:0]      frame_o,
  output logic                             kill_o
);

  logic                        valid_q, valid_d;
  logic [lrl_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic                        kill_q;
  logic                        shift;
  logic                        post_valid;
  logic [lrl_pkg::FRAME_W-1:0] post_frame;

  // at or after the removed position: take the neighbor's entry
  assign shift      = shift_i | kill_q;
  assign post_valid = shift ? next_valid_i : valid_q;
  assign post_frame = shift ? next_frame_i : frame_q;

  always_comb begin
    valid_d = post_valid;
    frame_d = post_frame;
    if (ctl_i.ins && !post_valid && prev_post_valid_i) begin
      valid_d = 1'b1;
      frame_d = ctl_i.ins_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      kill_q  <= 1'b0;
    end else begin
      if (ctl_i.accept) begin
        kill_q <= ctl_i.find && valid_q && (frame_q == ctl_i.cmp_frame);
      end else if (ctl_i.exec) begin
        kill_q <= 1'b0;
      end
      if (ctl_i.exec) begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      frame_q <= frame_d;
    end
  end

  assign shift_o      = shift;
  assign post_valid_o = post_valid;
  assign valid_o      = valid_q;
  assign frame_o      = frame_q;
  assign kill_o       = kill_q;

endmodule
`default_nettype wire

// File: rtl/core/lru_replacement_list_core.sv
// Top level of the LRU replacement list: request control and row of list cells.
//
// Usage: drive req_type_i and frame_id_i and raise start_i; the item is taken
// at a rising edge where start_i is high and busy_o is low. Request codes:
// insert/touch, victim, erase; the unused code is ignored with ok_o low.
// The item is compared against every cell in the accept cycle; the next cycle
// shifts the cells after the removed entry down by one and appends an insert
// at the tail. The result (ok_o, victim_frame_o, list_size_o) is shown with
// done_o for exactly one cycle, registered at the end of the shift cycle, and
// is taken at the edge that ends it: the receiver cannot stall. busy_o is
// high for one cycle after each accept, so a new item is not taken until the
// compare cycle and the shift cycle of the cell row are through. The result
// cycle overlaps the next accept. Reset clears all valid bits and the size
// count; the list starts empty and the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none
module lru_replacement_list_core #(
  parameter int unsigned FRAMES = lrl_pkg::FRAMES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [lrl_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic [lrl_pkg::FRAME_W-1:0] frame_id_i,
  output logic                             done_o,
  output logic                             ok_o,
  output logic [lrl_pkg::FRAME_W-1:0]      victim_frame_o,
  output logic [lrl_pkg::SIZE_W-1:0]       list_size_o
);

  localparam int unsigned CW = $clog2(FRAMES + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                      state_q;
  logic                        accept;
  logic                        ins_q, victim_q, erase_q;
  logic [lrl_pkg::FRAME_W-1:0] frame_q;
  logic [CW-1:0]               count_q, count_d;
  logic                        done_q, ok_q;
  logic [lrl_pkg::FRAME_W-1:0] victim_q_frame;
  lrl_pkg::cell_ctl_t          ctl;

  logic [FRAMES:0]                  shift_chain;
  logic [FRAMES:0]                  post_valid_chain;
  logic [FRAMES:0]                  valid_chain;
  logic [FRAMES:0][lrl_pkg::FRAME_W-1:0] frame_chain;
  logic [FRAMES-1:0]                kill;
  logic                             hit;
  logic                             ok_d;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    ctl.accept    = accept;
    ctl.find      = (req_type_i == lrl_pkg::REQ_INSERT) || (req_type_i == lrl_pkg::REQ_ERASE);
    ctl.cmp_frame = frame_id_i;
    ctl.exec      = (state_q == ST_EXEC);
    ctl.ins       = (state_q == ST_EXEC) && ins_q;
    ctl.ins_frame = frame_q;
  end

  // victim removes the head, so the whole row shifts
  assign shift_chain[0]      = victim_q;
  assign post_valid_chain[0] = 1'b1;
  assign valid_chain[FRAMES] = 1'b0;
  assign frame_chain[FRAMES] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrl_cell u_cell (
      .clk_i             (clk_i),
      .rst_ni            (rst_ni),
      .ctl_i             (ctl),
      .shift_i           (shift_chain[i]),
      .shift_o           (shift_chain[i+1]),
      .next_valid_i      (valid_chain[i+1]),
      .next_frame_i      (frame_chain[i+1]),
      .prev_post_valid_i (post_valid_chain[i]),
      .post_valid_o      (post_valid_chain[i+1]),
      .valid_o           (valid_chain[i]),
      .frame_o           (frame_chain[i]),
      .kill_o            (kill[i])
    );
  end

  assign hit     = victim_q ? valid_chain[0] : (|kill);
  assign ok_d    = ins_q || (victim_q && valid_chain[0]) || (erase_q && (|kill));
  assign count_d = count_q - CW'(hit) + CW'(ins_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ins_q    <= 1'b0;
      victim_q <= 1'b0;
      erase_q  <= 1'b0;
      count_q  <= '0;
      done_q   <= 1'b0;
      ok_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q  <= ST_EXEC;
            ins_q    <= (req_type_i == lrl_pkg::REQ_INSERT) &&
                        (32'(frame_id_i) < FRAMES);
            victim_q <= (req_type_i == lrl_pkg::REQ_VICTIM);
            erase_q  <= (req_type_i == lrl_pkg::REQ_ERASE);
          end
        end
        ST_EXEC: begin
          state_q  <= ST_IDLE;
          count_q  <= count_d;
          done_q   <= 1'b1;
          ok_q     <= ok_d;
          ins_q    <= 1'b0;
          victim_q <= 1'b0;
          erase_q  <= 1'b0;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= frame_id_i;
    end
    if (state_q == ST_EXEC) begin
      victim_q_frame <= (victim_q && valid_chain[0]) ? frame_chain[0] : '0;
    end
  end

  assign busy_o         = (state_q == ST_EXEC);
  assign done_o         = done_q;
  assign ok_o           = ok_q;
  assign victim_frame_o = victim_q_frame;
  assign list_size_o    = lrl_pkg::SIZE_W'(count_q);

endmodule
`default_nettype wire

// File: test/lru_replacement_list_checker.sv
// Request monitor, recency-list predictor and result scoreboard for the LRU replacement list.
`timescale 1ns / 1ps
module lru_replacement_list_checker #(
  parameter int unsigned FRAMES = lrl_pkg::FRAMES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [lrl_pkg::REQ_W-1:0]   req_type_i,
  input  logic [lrl_pkg::FRAME_W-1:0] frame_id_i,
  input  logic                        done_i,
  input  logic                        ok_i,
  input  logic [lrl_pkg::FRAME_W-1:0] victim_frame_i,
  input  logic [lrl_pkg::SIZE_W-1:0]  list_size_i,
  input  logic                        finish_i,
  output int                          fail_cnt_o,
  output int                          pending_o,
  output int                          result_cnt_o,
  output int                          peak_size_o
);

  typedef struct packed {
    logic                        ok;
    logic [lrl_pkg::FRAME_W-1:0] victim;
    logic [lrl_pkg::SIZE_W-1:0]  size;
  } lru_result_t;

  logic [lrl_pkg::FRAME_W-1:0] recency_q[$];
  lru_result_t                 expected_q[$];
  int                          fails;
  int                          results;
  int                          peak;
  logic                        leftover_checked;

  // Applies one request to the recency list, oldest frame at index 0.
  function automatic lru_result_t apply_request(logic [lrl_pkg::REQ_W-1:0] req,
                                                logic [lrl_pkg::FRAME_W-1:0] frame);
    lru_result_t r;
    int          pos;
    r   = '0;
    pos = -1;
    foreach (recency_q[i]) if (pos < 0 && recency_q[i] == frame) pos = i;
    case (req)
      lrl_pkg::REQ_INSERT: begin
        if (frame < FRAMES) begin
          if (pos >= 0) recency_q.delete(pos);
          if (recency_q.size() < FRAMES) begin
            recency_q.insert(recency_q.size(), frame);
            r.ok = 1'b1;
          end
        end
      end
      lrl_pkg::REQ_VICTIM: begin
        if (recency_q.size() > 0) begin
          r.victim = recency_q[0];
          recency_q.delete(0);
          r.ok     = 1'b1;
        end
      end
      lrl_pkg::REQ_ERASE: begin
        if (pos >= 0) begin
          recency_q.delete(pos);
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.size = lrl_pkg::SIZE_W'(recency_q.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lru_result_t exp_r;
    if (!rst_ni) begin
      recency_q.delete();
      expected_q.delete();
      fails            = 0;
      results          = 0;
      peak             = 0;
      leftover_checked = 1'b0;
    end else begin
      if (done_i) begin
        results++;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result without pending item: expected none, %s ok=%0d victim=%0d size=%0d",
                   $time, "actual", ok_i, victim_frame_i, list_size_i);
        end else begin
          exp_r = expected_q[0];
          expected_q.delete(0);
          if (ok_i !== exp_r.ok) begin
            fails++;
            $display("%0t: ok mismatch: expected %0d, actual %0d", $time, exp_r.ok, ok_i);
          end
          if (victim_frame_i !== exp_r.victim) begin
            fails++;
            $display("%0t: victim_frame mismatch: expected %0d, actual %0d",
                     $time, exp_r.victim, victim_frame_i);
          end
          if (list_size_i !== exp_r.size) begin
            fails++;
            $display("%0t: list_size mismatch: expected %0d, actual %0d",
                     $time, exp_r.size, list_size_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        exp_r = apply_request(req_type_i, frame_id_i);
        expected_q.insert(expected_q.size(), exp_r);
        if (int'(exp_r.size) > peak) peak = exp_r.size;
      end
      if (finish_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_q.size() != 0) begin
          fails++;
          $display("%0t: results never seen: expected 0 pending, actual %0d",
                   $time, expected_q.size());
        end
      end
    end
    fail_cnt_o   <= fails;
    pending_o    <= expected_q.size();
    result_cnt_o <= results;
    peak_size_o  <= peak;
  end

endmodule

// File: test/lru_replacement_list_core_test.sv
// Testbench top for the LRU replacement list: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module lru_replacement_list_core_test;

  localparam logic [lrl_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_TARGET    = 1700;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [lrl_pkg::REQ_W-1:0]   req_type_i;
  logic [lrl_pkg::FRAME_W-1:0] frame_id_i;
  logic                        done_o;
  logic                        ok_o;
  logic [lrl_pkg::FRAME_W-1:0] victim_frame_o;
  logic [lrl_pkg::SIZE_W-1:0]  list_size_o;
  logic                        finish_chk;
  int                          fail_cnt;
  int                          pending;
  int                          result_cnt;
  int                          peak_size;
  int                          idle_cycles;
  int                          sent_cnt;
  int                          op_cnt [4];
  logic                        no_gaps;

  lru_replacement_list_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .frame_id_i     (frame_id_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .victim_frame_o (victim_frame_o),
    .list_size_o    (list_size_o)
  );

  lru_replacement_list_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_type_i     (req_type_i),
    .frame_id_i     (frame_id_i),
    .done_i         (done_o),
    .ok_i           (ok_o),
    .victim_frame_i (victim_frame_o),
    .list_size_i    (list_size_o),
    .finish_i       (finish_chk),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .result_cnt_o   (result_cnt),
    .peak_size_o    (peak_size)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no progress", $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic [lrl_pkg::REQ_W-1:0] req,
                              input logic [lrl_pkg::FRAME_W-1:0] frame);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start_i    <= 1'b0;
      req_type_i <= lrl_pkg::REQ_W'($urandom_range(0, 3));
      frame_id_i <= lrl_pkg::FRAME_W'($urandom_range(0, 63));
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= req;
    frame_id_i <= frame;
    do @(posedge clk_i); while (busy_o);
    sent_cnt++;
    op_cnt[req]++;
  endtask

  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [lrl_pkg::REQ_W-1:0] pick_op(int ins_pct, int vic_pct, int era_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return lrl_pkg::REQ_INSERT;
    if (r < ins_pct + vic_pct) return lrl_pkg::REQ_VICTIM;
    if (r < ins_pct + vic_pct + era_pct) return lrl_pkg::REQ_ERASE;
    return REQ_UNUSED;
  endfunction

  initial begin
    int unsigned mode;
    int unsigned base;
    int unsigned stride;
    int unsigned n;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_type_i  = lrl_pkg::REQ_INSERT;
    frame_id_i  = '0;
    finish_chk  = 1'b0;
    idle_cycles = 0;
    sent_cnt    = 0;
    no_gaps     = 1'b0;
    foreach (op_cnt[i]) op_cnt[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, touches at head/middle/tail, absent erase, unused code
    send_request(lrl_pkg::REQ_VICTIM, 6'd0);
    send_request(lrl_pkg::REQ_ERASE,  6'd5);
    send_request(REQ_UNUSED,          6'd63);
    send_request(lrl_pkg::REQ_INSERT, 6'd0);
    send_request(lrl_pkg::REQ_INSERT, 6'd63);
    send_request(lrl_pkg::REQ_INSERT, 6'd21);
    send_request(lrl_pkg::REQ_INSERT, 6'd42);
    send_request(lrl_pkg::REQ_INSERT, 6'd0);
    send_request(lrl_pkg::REQ_INSERT, 6'd42);
    send_request(lrl_pkg::REQ_INSERT, 6'd21);
    send_request(lrl_pkg::REQ_ERASE,  6'd63);
    send_request(lrl_pkg::REQ_ERASE,  6'd63);
    send_request(REQ_UNUSED,          6'd21);
    send_request(lrl_pkg::REQ_VICTIM, 6'd63);
    send_request(lrl_pkg::REQ_VICTIM, 6'd0);
    send_request(lrl_pkg::REQ_VICTIM, 6'd0);
    send_request(lrl_pkg::REQ_VICTIM, 6'd0);
    send_request(lrl_pkg::REQ_INSERT, 6'd63);
    send_request(lrl_pkg::REQ_ERASE,  6'd63);
    send_request(lrl_pkg::REQ_VICTIM, 6'd42);
    wait_for_results();

    while (sent_cnt < ITEM_TARGET + 20) begin
      mode    = $urandom_range(0, 3);
      no_gaps = ($urandom_range(0, 3) == 0);
      base    = $urandom_range(0, 63);
      case (mode)
        0: begin
          // sweep the frames in a permuted order, mixed with random requests, so the list fills up
          stride = 2 * $urandom_range(0, 31) + 1;
          for (int k = 0; k < 64; k++) begin
            if ($urandom_range(0, 9) == 0)
              send_request(pick_op(30, 30, 30), lrl_pkg::FRAME_W'($urandom_range(0, 63)));
            else
              send_request(lrl_pkg::REQ_INSERT, lrl_pkg::FRAME_W'(base + k * stride));
          end
        end
        1: begin
          n = $urandom_range(20, 70);
          repeat (n) send_request(pick_op(5, 75, 18), lrl_pkg::FRAME_W'($urandom_range(0, 63)));
        end
        2: begin
          repeat (60) send_request(pick_op(45, 22, 29),
                                   lrl_pkg::FRAME_W'(base + $urandom_range(0, 7)));
        end
        default: begin
          repeat (60) send_request(pick_op(40, 25, 30),
                                   lrl_pkg::FRAME_W'($urandom_range(0, 63)));
        end
      endcase
      if ($urandom_range(0, 3) == 0) wait_for_results();
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    finish_chk <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Ran %0d requests: %0d insert, %0d victim, %0d erase, %0d unused code",
             sent_cnt, op_cnt[lrl_pkg::REQ_INSERT], op_cnt[lrl_pkg::REQ_VICTIM],
             op_cnt[lrl_pkg::REQ_ERASE], op_cnt[REQ_UNUSED]);
    $display("Checked %0d results; the list held up to %0d frames", result_cnt, peak_size);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lrl_pkg.sv
rtl/core/lrl_cell.sv
rtl/core/lru_replacement_list_core.sv
test/lru_replacement_list_checker.sv
test/lru_replacement_list_core_test.sv
